/* design/nps_pkg.sv */
// Shared codes and controller/datapath handshake types for the nearest point search unit.
package nps_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic clear;
    logic append;
    logic query_start;
    logic scan_issue;
    logic push;
  } nps_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic last_issue;
    logic pipe_busy;
    logic out_free;
  } nps_stat_t;

endpackage

/* design/nps_if.sv */
// Valid/ready item channels for requests and results of the nearest point search unit.
interface nps_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;

  modport source (output valid, operation, coord_x, coord_y, input ready);
  modport sink (input valid, operation, coord_x, coord_y, output ready);
endinterface

interface nps_out_if #(
  parameter int COORD_BITS = 16,
  parameter int INDEX_BITS = 10
);
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic signed [COORD_BITS-1:0] nearest_x;
  logic signed [COORD_BITS-1:0] nearest_y;
  logic [INDEX_BITS-1:0]        nearest_index;
  logic                         store_full;

  modport source (output valid, found, nearest_x, nearest_y, nearest_index, store_full,
                  input ready);
  modport sink (input valid, found, nearest_x, nearest_y, nearest_index, store_full,
                output ready);
endinterface

/* design/nps_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module nps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/nps_ctrl.sv */
// Controller state machine that sequences clear, append and query scans.
module nps_ctrl import nps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_operation,
  output logic       in_ready,
  input  nps_stat_t  stat,
  output nps_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_operation)
            OP_CLEAR: begin
              cmd.clear = 1'b1;
            end
            OP_APPEND: begin
              cmd.append = 1'b1;
              state_next = S_PUSH;
            end
            OP_QUERY: begin
              cmd.query_start = 1'b1;
              state_next      = stat.count_zero ? S_PUSH : S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.last_issue) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!stat.pipe_busy) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/nps_datapath.sv */
// Point store, scan pipeline for squared distances, best-match tracking and result register.
module nps_datapath import nps_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  nps_cmd_t                     cmd,
  output nps_stat_t                    stat,
  nps_out_if.source                    rsp
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int AW    = COORD_BITS + 1;
  localparam int DW    = 2 * AW;
  localparam int CB    = COORD_BITS;

  logic [CNT_W-1:0]    count;
  logic                full;
  logic [IDX_W-1:0]    addr;
  logic [2*CB-1:0]     rd_data;
  logic signed [CB-1:0] qx;
  logic signed [CB-1:0] qy;

  logic [4:1]          v;
  logic [IDX_W-1:0]    idx1, idx2, idx3, idx4;
  logic [CB-1:0]       x2, y2, x3, y3, x4, y4;
  logic [AW-1:0]       dxa, dya;
  logic [DW-1:0]       sqx, sqy, dist_sum;
  logic signed [AW-1:0] sdx, sdy;
  logic [CB-1:0]       px, py;

  logic                best_valid;
  logic [DW-1:0]       best_dist;
  logic                res_found;
  logic [CB-1:0]       res_x, res_y;
  logic [IDX_W-1:0]    res_idx;
  logic                res_full;
  logic                out_valid;

  assign full = (count == CNT_W'(MAX_POINTS));

  nps_ram #(
    .WIDTH (2 * CB),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.append && !full),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data ({in_x, in_y}),
    .rd_en   (cmd.scan_issue),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  assign px  = rd_data[2*CB-1:CB];
  assign py  = rd_data[CB-1:0];
  assign sdx = $signed({px[CB-1], px}) - $signed({qx[CB-1], qx});
  assign sdy = $signed({py[CB-1], py}) - $signed({qy[CB-1], qy});

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.append && !full) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      qx   <= in_x;
      qy   <= in_y;
      addr <= '0;
    end else if (cmd.scan_issue) begin
      addr <= addr + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[3:1], cmd.scan_issue};
    end
  end

  always_ff @(posedge clk) begin
    idx1     <= addr;
    dxa      <= sdx[AW-1] ? AW'(-sdx) : AW'(sdx);
    dya      <= sdy[AW-1] ? AW'(-sdy) : AW'(sdy);
    x2       <= px;
    y2       <= py;
    idx2     <= idx1;
    sqx      <= dxa * dxa;
    sqy      <= dya * dya;
    x3       <= x2;
    y3       <= y2;
    idx3     <= idx2;
    dist_sum <= sqx + sqy;
    x4       <= x3;
    y4       <= y3;
    idx4     <= idx3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
    end else if (cmd.query_start) begin
      best_valid <= 1'b0;
    end else if (v[4]) begin
      best_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      res_found <= 1'b0;
      res_x     <= '0;
      res_y     <= '0;
      res_idx   <= full ? '0 : count[IDX_W-1:0];
      res_full  <= full;
    end else if (cmd.query_start) begin
      res_found <= 1'b0;
      res_x     <= '0;
      res_y     <= '0;
      res_idx   <= '0;
      res_full  <= 1'b0;
    end else if (v[4] && (!best_valid || dist_sum <= best_dist)) begin
      best_dist <= dist_sum;
      res_found <= 1'b1;
      res_x     <= x4;
      res_y     <= y4;
      res_idx   <= idx4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rsp.found         <= res_found;
      rsp.nearest_x     <= res_x;
      rsp.nearest_y     <= res_y;
      rsp.nearest_index <= res_idx;
      rsp.store_full    <= res_full;
    end
  end

  assign rsp.valid = out_valid;

  assign stat.count_zero = (count == '0);
  assign stat.last_issue = ((CNT_W'(addr) + CNT_W'(1)) == count);
  assign stat.pipe_busy  = |v;
  assign stat.out_free   = !out_valid || rsp.ready;

endmodule

/* design/nearest_point_search_unit.sv */
// Top level of the nearest point search unit: controller, datapath and point store.
// Clear gives no item; an append or a query on an empty store goes straight to the push state,
// where its result is registered into the output once the output is free. A query on a
// nonempty store first scans the point store, one stored point read per cycle, waits for the
// distance pipeline to drain and then pushes its result. One item is in work at a time.
// Synchronous reset clears the point count and control state; store contents are not cleared.
module nearest_point_search_unit import nps_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  nps_in_if.sink    req,
  nps_out_if.source rsp
);

  nps_cmd_t  cmd;
  nps_stat_t stat;

  nps_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (req.valid),
    .in_operation (req.operation),
    .in_ready     (req.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  nps_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .in_x (req.coord_x),
    .in_y (req.coord_y),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule
